### sv/pic_pkg.sv
package pic_pkg;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_RAISE = 3'd2,
        OP_ACK   = 3'd3,
        OP_TICK  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        INIT_NONE = 2'd0,
        INIT_ICW2 = 2'd1,
        INIT_ICW3 = 2'd2,
        INIT_ICW4 = 2'd3
    } t_init_step;

    // Command word decode
    localparam logic [7:0] ICW1_MASK     = 8'hf4;
    localparam logic [7:0] ICW1_CODE     = 8'h10;
    localparam logic [7:0] OCW2_MASK     = 8'h18;
    localparam logic [7:0] OCW3_MASK     = 8'h98;
    localparam logic [7:0] OCW3_CODE     = 8'h08;
    localparam logic [7:0] EOI_MASK      = 8'hf9;
    localparam logic [7:0] EOI_NONSPEC   = 8'h20;
    localparam logic [7:0] EOI_SPECIFIC  = 8'h60;
    localparam logic [7:0] MASK_RESET    = 8'hff;
    localparam logic [1:0] RSEL_IRR      = 2'b10;
    localparam logic [1:0] RSEL_ISR      = 2'b11;

    typedef struct packed {
        logic [2:0] op;
        logic       addr;
        logic [7:0] data;
        logic [2:0] irq_line;
        logic       level;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] vector;
        logic       int_request;
    } t_result;

    // Index of the lowest set bit; 7 when none set
    function automatic logic [2:0] lowest_index(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd7;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

### sv/pic_if.sv
interface pic_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic       addr;
    logic [7:0] data;
    logic [2:0] irq_line;
    logic       level;

    modport source (output valid, op, addr, data, irq_line, level, input ready);
    modport sink   (input valid, op, addr, data, irq_line, level, output ready);
endinterface

interface pic_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] vector;
    logic       int_request;

    modport source (output valid, read_data, vector, int_request, input ready);
    modport sink   (input valid, read_data, vector, int_request, output ready);
endinterface

### sv/pic_core.sv
module pic_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  pic_pkg::t_item    i_item,
    output pic_pkg::t_result  o_result
);

    logic [7:0]          r_irr, n_irr;
    logic [7:0]          r_isr, n_isr;
    logic [7:0]          r_imr, n_imr;
    logic [1:0]          r_icw_flags, n_icw_flags;
    logic [4:0]          r_base, n_base;
    logic                r_aeoi, n_aeoi;
    logic                r_rsel, n_rsel;
    pic_pkg::t_init_step r_init_step, n_init_step;

    logic       w_wr0, w_wr1, w_icw1, w_ocw2, w_ocw3, w_icwn;
    logic [7:0] w_irr_low, w_isr_low;

    assign w_wr0  = (i_item.op == pic_pkg::OP_WRITE) && !i_item.addr;
    assign w_wr1  = (i_item.op == pic_pkg::OP_WRITE) && i_item.addr;
    assign w_icw1 = w_wr0 && ((i_item.data & pic_pkg::ICW1_MASK) == pic_pkg::ICW1_CODE);
    assign w_ocw2 = w_wr0 && !w_icw1 && ((i_item.data & pic_pkg::OCW2_MASK) == 8'h00);
    assign w_ocw3 = w_wr0 && !w_icw1 && !w_ocw2
                    && ((i_item.data & pic_pkg::OCW3_MASK) == pic_pkg::OCW3_CODE);
    assign w_icwn = w_wr1 && (r_init_step != pic_pkg::INIT_NONE);

    assign w_irr_low = r_irr & (~r_irr + 8'd1);
    assign w_isr_low = r_isr & (~r_isr + 8'd1);

    // Init sequence next state
    always_comb begin
        n_init_step = r_init_step;
        if (w_icw1) begin
            n_init_step = pic_pkg::INIT_ICW2;
        end else if (w_icwn) begin
            unique case (r_init_step)
                pic_pkg::INIT_ICW2: begin
                    if (r_icw_flags[1]) begin
                        n_init_step = r_icw_flags[0] ? pic_pkg::INIT_ICW4 : pic_pkg::INIT_NONE;
                    end else begin
                        n_init_step = pic_pkg::INIT_ICW3;
                    end
                end
                pic_pkg::INIT_ICW3: begin
                    n_init_step = r_icw_flags[0] ? pic_pkg::INIT_ICW4 : pic_pkg::INIT_NONE;
                end
                default: begin
                    n_init_step = pic_pkg::INIT_NONE;
                end
            endcase
        end
    end

    // Register file updates
    always_comb begin
        n_irr       = r_irr;
        n_isr       = r_isr;
        n_imr       = r_imr;
        n_icw_flags = r_icw_flags;
        n_base      = r_base;
        n_aeoi      = r_aeoi;
        n_rsel      = r_rsel;
        if (w_icw1) begin
            n_icw_flags = i_item.data[1:0];
            n_irr       = 8'h00;
            n_isr       = 8'h00;
            n_imr       = pic_pkg::MASK_RESET;
            n_base      = 5'd0;
            n_aeoi      = 1'b0;
            n_rsel      = 1'b1;
        end else if (w_ocw2) begin
            if ((i_item.data & pic_pkg::EOI_MASK) == pic_pkg::EOI_NONSPEC) begin
                n_isr = r_isr & (r_isr - 8'd1);
            end else if ((i_item.data & pic_pkg::EOI_MASK) == pic_pkg::EOI_SPECIFIC) begin
                n_isr = r_isr & ~(8'd1 << i_item.data[2:0]);
            end
        end else if (w_ocw3) begin
            if (i_item.data[1:0] == pic_pkg::RSEL_IRR) begin
                n_rsel = 1'b1;
            end else if (i_item.data[1:0] == pic_pkg::RSEL_ISR) begin
                n_rsel = 1'b0;
            end
        end else if (w_icwn) begin
            if (r_init_step == pic_pkg::INIT_ICW2) begin
                n_base = i_item.data[7:3];
            end else if (r_init_step == pic_pkg::INIT_ICW4) begin
                n_aeoi = i_item.data[1];
            end
        end else if (w_wr1) begin
            n_imr = i_item.data;
        end else if ((i_item.op == pic_pkg::OP_RAISE) && i_item.level) begin
            n_irr = r_irr | ((8'd1 << i_item.irq_line) & ~r_imr);
        end else if ((i_item.op == pic_pkg::OP_ACK) && (w_irr_low != 8'h00)) begin
            n_irr = r_irr & ~w_irr_low;
            if (!r_aeoi) begin
                n_isr = r_isr | w_irr_low;
            end
        end
    end

    // Result
    always_comb begin
        o_result = '0;
        case (i_item.op)
            pic_pkg::OP_READ: begin
                if (!i_item.addr) begin
                    o_result.read_data = r_rsel ? r_irr : r_isr;
                end else begin
                    o_result.read_data = r_imr;
                end
            end
            pic_pkg::OP_ACK: begin
                if (w_irr_low != 8'h00) begin
                    o_result.vector = {r_base, pic_pkg::lowest_index(w_irr_low)};
                end
            end
            pic_pkg::OP_TICK: begin
                o_result.int_request = (w_irr_low != 8'h00)
                                       && ((w_isr_low == 8'h00) || (w_irr_low < w_isr_low));
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irr       <= 8'h00;
            r_isr       <= 8'h00;
            r_imr       <= pic_pkg::MASK_RESET;
            r_icw_flags <= 2'b00;
            r_base      <= 5'd0;
            r_aeoi      <= 1'b0;
            r_rsel      <= 1'b1;
            r_init_step <= pic_pkg::INIT_NONE;
        end else if (i_fire) begin
            r_irr       <= n_irr;
            r_isr       <= n_isr;
            r_imr       <= n_imr;
            r_icw_flags <= n_icw_flags;
            r_base      <= n_base;
            r_aeoi      <= n_aeoi;
            r_rsel      <= n_rsel;
            r_init_step <= n_init_step;
        end
    end

endmodule

### sv/programmable_interrupt_controller_unit.sv
// A transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle while the sink is ready; the input and the result
// registers are each freed in the cycle they hand on, so the block streams without gaps.
// Reset (synchronous, active low): pipeline emptied, IRR and ISR cleared, mask all ones,
// no init sequence pending, read-back selects IRR.
module programmable_interrupt_controller_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pic_item_if.sink      i_item,
    pic_result_if.source  o_result
);

    // Input register: holds the transaction being evaluated against the state
    logic             r_in_valid;
    pic_pkg::t_item   r_in;

    // Result register: holds the finished result until the sink takes it
    logic             r_out_valid;
    pic_pkg::t_result r_out;

    logic             w_out_free;
    logic             w_fire;
    pic_pkg::t_result w_result;

    // Advance the held transaction when the result register is empty or being emptied.
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_fire     = r_in_valid && w_out_free;

    // Accept a new transaction whenever the input register is empty or moves on.
    assign i_item.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.op       <= i_item.op;
            r_in.addr     <= i_item.addr;
            r_in.data     <= i_item.data;
            r_in.irq_line <= i_item.irq_line;
            r_in.level    <= i_item.level;
        end
    end

    // Register file, command decode, priority resolution; state commits on w_fire.
    pic_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    // Drive the result channel straight from the result register.
    assign o_result.valid       = r_out_valid;
    assign o_result.read_data   = r_out.read_data;
    assign o_result.vector      = r_out.vector;
    assign o_result.int_request = r_out.int_request;

endmodule
